// ===== sv/tld_pkg.sv =====
// ----------------------------------------------------------------------------
// tld_pkg: shared types and constants
// Link payload passed between cells, register map and fixed filter constants.
// ----------------------------------------------------------------------------
package tld_pkg;

  // Data handed from one cell to the next.
  typedef struct packed {
    logic [7:0] sample;  // raw unsigned sample, carried to the output stage
    logic       start;   // first sample of a new waveform
    logic [7:0] env;     // envelope produced by the cell
  } tld_link_t;

  // Register map, indexed by word address.
  typedef enum logic {
    REG_ATTACK  = 1'b0,
    REG_RELEASE = 1'b1
  } tld_reg_t;

  localparam logic [8:0] UNITY         = 9'd256;
  localparam logic [7:0] CENTER        = 8'd128;
  localparam logic [8:0] ATTACK_RESET  = 9'd242;
  localparam logic [8:0] RELEASE_RESET = 9'd255;
  localparam logic [8:0] OUT_MAX       = 9'd383;  // CENTER + 255

endpackage

// ===== sv/trough_lift_dc_bend.sv =====
// ----------------------------------------------------------------------------
// trough_lift_dc_bend: streaming trough-lift DC bend
// Follower cell, a chain of smoother cells and an output clamp cell.
// ----------------------------------------------------------------------------
// Path: the follower loads an input transaction at the edge that accepts it,
// then each smoother and the output clamp register it in turn, and out_valid
// rises once the clamp holds the result. Throughput: one transaction per cycle
// while out_ready stays high; each cell updates its one level register per
// item, so the chain of cells sets the rate.
// Reset (rst_n, synchronous, active low) empties the chain, clears all filter
// levels to zero and loads the coefficients with 242 (attack) and 255 (release).
// ----------------------------------------------------------------------------
module trough_lift_dc_bend #(
  parameter int SMOOTH_PASSES = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_sample_in,
  input  logic        in_start_of_sample,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_sample_out,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Coefficient registers. Values above 256 are clamped to 256 inside the
  // follower, which makes that pole hold its level.
  logic [8:0] attack_coeff_r;
  logic [8:0] release_coeff_r;
  logic       cfg_write;
  tld_pkg::tld_reg_t cfg_reg;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_reg   = tld_pkg::tld_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_coeff_r  <= tld_pkg::ATTACK_RESET;
      release_coeff_r <= tld_pkg::RELEASE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg)
        tld_pkg::REG_ATTACK:  attack_coeff_r  <= pwdata[8:0];
        tld_pkg::REG_RELEASE: release_coeff_r <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg)
      tld_pkg::REG_ATTACK:  prdata = {23'd0, attack_coeff_r};
      tld_pkg::REG_RELEASE: prdata = {23'd0, release_coeff_r};
      default:              prdata = 32'd0;
    endcase
  end

  // Links between cells. Link 0 leaves the follower; link k + 1 leaves
  // smoother k. Every cell has its own valid/ready pair, so a stall at the
  // output only backs up as far as the first empty cell.
  tld_pkg::tld_link_t link       [SMOOTH_PASSES + 1];
  logic               link_valid [SMOOTH_PASSES + 1];
  logic               link_ready [SMOOTH_PASSES + 1];

  tld_follow u_follow (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample       (in_sample_in),
    .start        (in_start_of_sample),
    .attack_coeff (attack_coeff_r),
    .rel_coeff    (release_coeff_r),
    .out_valid    (link_valid[0]),
    .out_ready    (link_ready[0]),
    .out_link     (link[0])
  );

  // Each smoother sees the same start mark as the follower, carried with its
  // item from cell to cell, and seeds itself with its own input on that item.
  for (genvar k = 0; k < SMOOTH_PASSES; k++) begin : g_smooth
    tld_smooth u_smooth (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (link_valid[k]),
      .in_ready  (link_ready[k]),
      .in_link   (link[k]),
      .out_valid (link_valid[k + 1]),
      .out_ready (link_ready[k + 1]),
      .out_link  (link[k + 1])
    );
  end

  // The output cell registers the result, so a waiting result never blocks
  // the cells in front of it while they still have room.
  tld_lift u_lift (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (link_valid[SMOOTH_PASSES]),
    .in_ready   (link_ready[SMOOTH_PASSES]),
    .in_link    (link[SMOOTH_PASSES]),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (out_sample_out)
  );

endmodule

// ===== sv/tld_follow.sv =====
// ----------------------------------------------------------------------------
// tld_follow: asymmetric trough follower cell
// One-pole follower on the clamped negated sample with attack/release poles.
// ----------------------------------------------------------------------------
module tld_follow (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          sample,
  input  logic                start,
  input  logic [8:0]          attack_coeff,
  input  logic [8:0]          rel_coeff,
  output logic                out_valid,
  input  logic                out_ready,
  output tld_pkg::tld_link_t  out_link
);

  logic               v_r;
  tld_pkg::tld_link_t link_r;
  logic [15:0]        level_r;
  logic [15:0]        level_nxt;
  logic [15:0]        level_base;
  logic [7:0]         depth;
  logic [15:0]        target;
  logic [8:0]         coeff_raw;
  logic [8:0]         coeff;
  logic [8:0]         inv_coeff;
  logic [24:0]        lvl_prod;
  logic [16:0]        dep_prod;
  logic [16:0]        sum;
  logic               take;

  assign in_ready = ~v_r | out_ready;
  assign take     = in_valid & in_ready;

  always_comb begin
    // Depth of the trough below center; zero for samples at or above it.
    depth      = (sample < tld_pkg::CENTER) ? 8'(9'd128 - {1'b0, sample}) : 8'd0;
    target     = {depth, 8'd0};
    level_base = start ? 16'd0 : level_r;
    coeff_raw  = (target > level_base) ? attack_coeff : rel_coeff;
    coeff      = (coeff_raw > tld_pkg::UNITY) ? tld_pkg::UNITY : coeff_raw;
    inv_coeff  = tld_pkg::UNITY - coeff;
    lvl_prod   = 25'(level_base) * 25'(coeff);
    // The target has a zero fraction, so its share is exact without a shift.
    dep_prod   = 17'(depth) * 17'(inv_coeff);
    sum        = lvl_prod[24:8] + dep_prod;
    level_nxt  = sum[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= 1'b0;
      level_r <= 16'd0;
    end else if (take) begin
      v_r     <= 1'b1;
      level_r <= level_nxt;
    end else if (out_ready) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      link_r.sample <= sample;
      link_r.start  <= start;
      link_r.env    <= level_nxt[15:8];
    end
  end

  assign out_valid = v_r;
  assign out_link  = link_r;

endmodule

// ===== sv/tld_smooth.sv =====
// ----------------------------------------------------------------------------
// tld_smooth: one-pole smoother cell
// Fixed 192/256 pole, seeded with its own input on the first sample.
// ----------------------------------------------------------------------------
module tld_smooth (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tld_pkg::tld_link_t  in_link,
  output logic                out_valid,
  input  logic                out_ready,
  output tld_pkg::tld_link_t  out_link
);

  logic               v_r;
  tld_pkg::tld_link_t link_r;
  logic [15:0]        level_r;
  logic [15:0]        level_nxt;
  logic [15:0]        level_base;
  logic [23:0]        prod;
  logic               take;

  assign in_ready = ~v_r | out_ready;
  assign take     = in_valid & in_ready;

  always_comb begin
    level_base = in_link.start ? {in_link.env, 8'd0} : level_r;
    // level * 192 as level * 128 + level * 64.
    prod       = 24'({level_base, 7'd0}) + 24'({level_base, 6'd0});
    level_nxt  = prod[23:8] + {2'd0, in_link.env, 6'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= 1'b0;
      level_r <= 16'd0;
    end else if (take) begin
      v_r     <= 1'b1;
      level_r <= level_nxt;
    end else if (out_ready) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      link_r.sample <= in_link.sample;
      link_r.start  <= in_link.start;
      link_r.env    <= level_nxt[15:8];
    end
  end

  assign out_valid = v_r;
  assign out_link  = link_r;

endmodule

// ===== sv/tld_lift.sv =====
// ----------------------------------------------------------------------------
// tld_lift: output cell
// Adds the smoothed envelope to the signed sample and clamps to 0..255.
// ----------------------------------------------------------------------------
module tld_lift (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tld_pkg::tld_link_t  in_link,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          sample_out
);

  logic       v_r;
  logic [7:0] sample_r;
  logic [7:0] sample_nxt;
  logic [8:0] total;
  logic [8:0] shifted;
  logic       take;

  assign in_ready = ~v_r | out_ready;
  assign take     = in_valid & in_ready;

  always_comb begin
    // total - 128 is the signed sample plus the envelope.
    total   = {1'b0, in_link.sample} + {1'b0, in_link.env};
    shifted = total - {1'b0, tld_pkg::CENTER};
    if (total < {1'b0, tld_pkg::CENTER}) begin
      sample_nxt = 8'd0;
    end else if (total > tld_pkg::OUT_MAX) begin
      sample_nxt = 8'd255;
    end else begin
      sample_nxt = shifted[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (take) begin
      v_r <= 1'b1;
    end else if (out_ready) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sample_r <= sample_nxt;
    end
  end

  assign out_valid  = v_r;
  assign sample_out = sample_r;

endmodule

// ===== verif/trough_lift_dc_bend_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trough_lift_dc_bend_test: self-checking testbench for the trough-lift bend
// Streams unsigned samples through the block, predicts every lifted sample
// with a local model of the trough follower and smoother chain, and compares
// each output transaction in order. The coefficients are reprogrammed over
// the configuration port between phases, and both sides idle at random.
// ----------------------------------------------------------------------------
module trough_lift_dc_bend_test;

  localparam int         SMOOTH_PASSES = 3;
  localparam int         LATENCY       = SMOOTH_PASSES + 2;
  localparam int         RESET_CYCLES  = 12;
  localparam int         STALL_LIMIT   = 2000;
  localparam int         SEGMENT_ITEMS = 275;
  localparam logic [8:0] SMOOTH_COEFF  = 9'd192;

  // Idle percentages per regime: sender, then receiver. The last regime
  // runs both sides flat out.
  localparam int TX_IDLE [3] = '{19, 46, 0};
  localparam int RX_IDLE [3] = '{46, 19, 0};

  // One row of stimulus. When known is set, want is the lifted sample that
  // the row must produce; otherwise the predictor supplies the expectation.
  // A row with retune set first drains the block and loads new coefficients.
  typedef struct packed {
    logic [7:0] sample;
    logic       first;
    logic       known;
    logic [7:0] want;
    logic       retune;
    logic [8:0] attack;
    logic [8:0] rel;
  } lift_row_t;

  typedef enum int {
    SHAPE_WALK,
    SHAPE_NOISE,
    SHAPE_RAIL,
    SHAPE_SQUARE,
    SHAPE_DIP
  } wave_shape_t;

  logic        clk                = 1'b0;
  logic        rst_n              = 1'b0;
  logic        in_valid           = 1'b0;
  logic        in_ready;
  logic [7:0]  in_sample_in       = 8'd0;
  logic        in_start_of_sample = 1'b0;
  logic        out_valid;
  logic        out_ready          = 1'b0;
  logic [7:0]  out_sample_out;
  logic        psel               = 1'b0;
  logic        penable            = 1'b0;
  logic        pwrite             = 1'b0;
  logic [2:0]  paddr              = 3'd0;
  logic [31:0] pwdata             = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  trough_lift_dc_bend #(
    .SMOOTH_PASSES(SMOOTH_PASSES)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample_in      (in_sample_in),
    .in_start_of_sample(in_start_of_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sample_out    (out_sample_out),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state. It mirrors the block's coefficient registers and filter
  // levels, and advances once per accepted input transaction.
  // --------------------------------------------------------------------------
  logic [8:0]  attack_pole  = tld_pkg::ATTACK_RESET;
  logic [8:0]  release_pole = tld_pkg::RELEASE_RESET;
  logic [15:0] trough_q     = 16'd0;
  logic [15:0] smooth_q [SMOOTH_PASSES] = '{default: 16'd0};

  lift_row_t   pending_rows_q [$];   // rows driven, waiting to be accepted
  logic [7:0]  lifted_q [$];         // expected lifted samples, oldest first

  int tx_idle_pct   = TX_IDLE[0];
  int rx_idle_pct   = RX_IDLE[0];
  int items_sent    = 0;
  int results_seen  = 0;
  int fail_count    = 0;
  int starts_seen   = 0;
  int settings_used = 0;
  int floor_hits    = 0;
  int ceiling_hits  = 0;
  int stall_cycles  = 0;

  // One-pole blend in 8.8: keep c/256 of the old level and take the rest
  // from the goal. A coefficient above unity acts as unity, so the level
  // holds. The result wraps to the 16-bit level register.
  function automatic logic [15:0] pole_blend(logic [15:0] level, logic [15:0] goal,
                                             logic [8:0] c);
    logic [8:0]  k;
    logic [31:0] kept;
    logic [31:0] taken;
    k     = (c > tld_pkg::UNITY) ? tld_pkg::UNITY : c;
    kept  = (32'(level) * k) >> 8;
    taken = (32'(goal) * (tld_pkg::UNITY - k)) >> 8;
    return 16'(kept + taken);
  endfunction

  // Advances the predictor by one sample and returns the lifted sample.
  function automatic logic [7:0] lift_sample(logic [7:0] raw, logic first);
    int          centered;
    int          sum;
    int          p;
    logic [15:0] goal;
    logic [7:0]  env;
    centered = int'(raw) - int'(tld_pkg::CENTER);
    // The follower tracks how far the sample dips below center.
    goal = (centered < 0) ? {8'(-centered), 8'h00} : 16'h0000;
    if (first) begin
      trough_q = 16'd0;
    end
    trough_q = pole_blend(trough_q, goal, (goal > trough_q) ? attack_pole : release_pole);
    env = trough_q[15:8];
    // Each smoother is seeded with its own input on a start mark, which makes
    // its first output equal to that input.
    for (p = 0; p < SMOOTH_PASSES; p++) begin
      if (first) begin
        smooth_q[p] = {env, 8'h00};
      end
      smooth_q[p] = pole_blend(smooth_q[p], {env, 8'h00}, SMOOTH_COEFF);
      env = smooth_q[p][15:8];
    end
    sum = centered + int'(env);
    if (sum < 0) begin
      sum = 0;
    end else if (sum > 255) begin
      sum = 255;
    end
    return 8'(sum);
  endfunction

  // --------------------------------------------------------------------------
  // Directed stimulus. The opening rows run before any start mark, so the
  // filters work from their reset levels. Later phases pin the coefficients
  // to their corners: an attack of zero jumps straight to the trough, a
  // coefficient of 256 or more freezes the pole, and a deep trough held
  // against a high sample drives the sum to the top of the range.
  // --------------------------------------------------------------------------
  lift_row_t directed_rows [25] = '{
    // Reset coefficients, no start mark yet.
    '{8'd200, 1'b0, 1'b1, 8'd72,  1'b0, 9'd0,   9'd0},
    '{8'd0,   1'b0, 1'b1, 8'd0,   1'b0, 9'd0,   9'd0},
    '{8'd255, 1'b0, 1'b0, 8'd0,   1'b0, 9'd0,   9'd0},
    '{8'd128, 1'b0, 1'b0, 8'd0,   1'b0, 9'd0,   9'd0},
    // Start marks clear the follower and reseed the smoothers.
    '{8'd255, 1'b1, 1'b1, 8'd127, 1'b0, 9'd0,   9'd0},
    '{8'd128, 1'b1, 1'b1, 8'd0,   1'b0, 9'd0,   9'd0},
    '{8'd0,   1'b1, 1'b1, 8'd0,   1'b0, 9'd0,   9'd0},
    '{8'd1,   1'b0, 1'b0, 8'd0,   1'b0, 9'd0,   9'd0},
    '{8'd127, 1'b0, 1'b0, 8'd0,   1'b0, 9'd0,   9'd0},
    '{8'd129, 1'b0, 1'b0, 8'd0,   1'b0, 9'd0,   9'd0},
    '{8'd254, 1'b0, 1'b0, 8'd0,   1'b0, 9'd0,   9'd0},
    '{8'd170, 1'b0, 1'b0, 8'd0,   1'b0, 9'd0,   9'd0},
    '{8'd85,  1'b0, 1'b0, 8'd0,   1'b0, 9'd0,   9'd0},
    // Instant attack, frozen release: the envelope locks at 128.
    '{8'd0,   1'b1, 1'b1, 8'd0,   1'b1, 9'd0,   9'd511},
    '{8'd255, 1'b0, 1'b1, 8'd255, 1'b0, 9'd0,   9'd0},
    '{8'd200, 1'b0, 1'b1, 8'd200, 1'b0, 9'd0,   9'd0},
    '{8'd128, 1'b0, 1'b1, 8'd128, 1'b0, 9'd0,   9'd0},
    // Frozen attack, instant release: the envelope never leaves zero.
    '{8'd0,   1'b1, 1'b1, 8'd0,   1'b1, 9'd256, 9'd0},
    '{8'd255, 1'b0, 1'b1, 8'd127, 1'b0, 9'd0,   9'd0},
    '{8'd64,  1'b0, 1'b1, 8'd0,   1'b0, 9'd0,   9'd0},
    // Near-instant attack, release just above unity.
    '{8'd0,   1'b1, 1'b0, 8'd0,   1'b1, 9'd1,   9'd257},
    '{8'd0,   1'b0, 1'b0, 8'd0,   1'b0, 9'd0,   9'd0},
    '{8'd255, 1'b0, 1'b0, 8'd0,   1'b0, 9'd0,   9'd0},
    // Half-way poles.
    '{8'd0,   1'b1, 1'b0, 8'd0,   1'b1, 9'd128, 9'd128},
    '{8'd192, 1'b0, 1'b0, 8'd0,   1'b0, 9'd0,   9'd0}
  };

  // --------------------------------------------------------------------------
  // Result side: the receiver drops ready at random, at the rate of the
  // current regime.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Monitor. Every accepted input transaction advances the predictor; a
  // directed row with a typed-in result uses that value as the expectation.
  // Every accepted output transaction is checked against the oldest one.
  always @(posedge clk) begin
    lift_row_t  row;
    logic [7:0] predicted;
    logic [7:0] want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        row = '0;
        if (pending_rows_q.size() != 0) begin
          row = pending_rows_q.pop_front();
        end
        predicted = lift_sample(in_sample_in, in_start_of_sample);
        lifted_q.push_back(row.known ? row.want : predicted);
        if (in_start_of_sample) begin
          starts_seen++;
        end
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (lifted_q.size() == 0) begin
          $error("sample_out: expected no transaction, got %0d", out_sample_out);
          fail_count++;
        end else begin
          want = lifted_q.pop_front();
          if (want == 8'd0) begin
            floor_hits++;
          end
          if (want == 8'd255) begin
            ceiling_hits++;
          end
          if (out_sample_out !== want) begin
            $error("sample_out: expected %0d, got %0d", want, out_sample_out);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog. Any handshake or register access counts as progress; a long
  // stretch without one means the block has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks. All of them are entered just after a rising edge and drive
  // with nonblocking assignments, so the block sees stable inputs.
  // --------------------------------------------------------------------------

  // Offers one input transaction, after a random gap, and returns once it has
  // been accepted. Valid stays high into the next call when there is no gap.
  task automatic send_row(lift_row_t row);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_sample_in       <= row.sample;
    in_start_of_sample <= row.first;
    pending_rows_q.push_back(row);
    do @(posedge clk); while (!(in_valid && in_ready));
    items_sent++;
  endtask

  // Writes one coefficient register, reads it back, and updates the
  // predictor's copy. Only called while nothing is in flight.
  task automatic program_coeff(tld_pkg::tld_reg_t which, logic [8:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // The register is loaded at the edge above; a second transfer reads it.
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[8:0] !== value) begin
      $error("%s readback: expected %0d, got %0d", which.name(), value, prdata[8:0]);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    if (which == tld_pkg::REG_ATTACK) begin
      attack_pole = value;
    end else begin
      release_pole = value;
    end
  endtask

  // Holds off the sender until every lifted sample has come back, lets the
  // pipeline settle, then loads a new pair of coefficients.
  task automatic retune(logic [8:0] attack, logic [8:0] rel);
    in_valid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    program_coeff(tld_pkg::REG_ATTACK, attack);
    program_coeff(tld_pkg::REG_RELEASE, rel);
    settings_used++;
  endtask

  // Random coefficients for 40 percent of picks; the rest come from the corners
  // and the reset values.
  function automatic logic [8:0] pick_coeff();
    logic [8:0] corners [8] = '{9'd0, 9'd1, 9'd128, 9'd242, 9'd255, 9'd256,
                                9'd257, 9'd511};
    if ($urandom_range(99) < 40) begin
      return 9'($urandom_range(0, 511));
    end
    return corners[$urandom_range(0, 7)];
  endfunction

  // Plays one short waveform. Most open with a start mark, as a real sample
  // would; the rest continue the previous waveform, and a stray start mark
  // now and then lands in the middle.
  task automatic play_waveform();
    wave_shape_t shape;
    lift_row_t   row;
    int          span;
    int          level;
    int          stride;
    int          lo;
    int          hi;
    int          k;
    logic        mark;
    shape  = wave_shape_t'($urandom_range(0, 4));
    span   = $urandom_range(1, 40);
    level  = $urandom_range(0, 255);
    stride = $urandom_range(1, 24);
    lo     = $urandom_range(0, 127);
    hi     = $urandom_range(128, 255);
    mark   = ($urandom_range(99) < 88);
    for (k = 0; k < span; k++) begin
      case (shape)
        SHAPE_WALK: begin
          level = level + int'($urandom_range(0, 2 * stride)) - stride;
        end
        SHAPE_NOISE: begin
          level = $urandom_range(0, 255);
        end
        SHAPE_RAIL: begin
          case ($urandom_range(0, 3))
            0: level = 0;
            1: level = 255;
            2: level = 128;
            default: level = $urandom_range(0, 255);
          endcase
        end
        SHAPE_SQUARE: begin
          level = ((k / stride) % 2 == 0) ? lo : hi;
        end
        default: begin
          // Deep trough with the odd spike above center.
          level = ($urandom_range(9) == 0) ? $urandom_range(128, 255) : $urandom_range(0, 40);
        end
      endcase
      if (level < 0) begin
        level = 0;
      end else if (level > 255) begin
        level = 255;
      end
      row        = '0;
      row.sample = 8'(level);
      row.first  = (k == 0) ? mark : ($urandom_range(199) == 0);
      send_row(row);
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int regime;
    int seg;
    int row_idx;
    int target;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows run under the first idling regime.
    for (row_idx = 0; row_idx < 25; row_idx++) begin
      if (directed_rows[row_idx].retune) begin
        retune(directed_rows[row_idx].attack, directed_rows[row_idx].rel);
      end
      send_row(directed_rows[row_idx]);
    end

    // Random waveforms: two coefficient settings per idling regime.
    for (regime = 0; regime < 3; regime++) begin
      tx_idle_pct = TX_IDLE[regime];
      rx_idle_pct = RX_IDLE[regime];
      for (seg = 0; seg < 2; seg++) begin
        retune(pick_coeff(), pick_coeff());
        target = items_sent + SEGMENT_ITEMS;
        while (items_sent < target) begin
          play_waveform();
        end
      end
    end

    // Drain, then give the pipeline time to show any stray transaction.
    in_valid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
    repeat (4 * LATENCY) @(posedge clk);

    $display("Streamed %0d samples with %0d start marks under %0d coefficient settings.",
             items_sent, starts_seen, settings_used);
    $display("Checked %0d lifted samples; %0d clamped at the floor, %0d at the ceiling.",
             results_seen, floor_hits, ceiling_hits);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
